### hw/rtl/tarp_pkg.sv
`timescale 1ns / 1ps

package tarp_pkg;

  localparam int MaxNotesDefault = 8;
  localparam int CapLimit        = 12;

  localparam int NoteW = 7;
  localparam int VelW  = 7;
  localparam int MsW   = 8;
  localparam int BpmW  = 9;
  localparam int AccW  = 10;
  localparam int PcW   = 5;

  localparam int BpmMin       = 20;
  localparam int BpmMax       = 300;
  localparam int BpmReset     = 120;
  localparam int MsPerMinute  = 60000;
  localparam int StepsPerBeat = 4;
  localparam int StepReset    = (MsPerMinute / BpmReset) / StepsPerBeat;

  localparam int DivW    = 16;
  localparam int DivCntW = 5;

  typedef logic [PcW-1:0] pc_t;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  localparam logic [1:0] PAT_BLOCK  = 2'd0;
  localparam logic [1:0] PAT_UP     = 2'd1;
  localparam logic [1:0] PAT_DOWN   = 2'd2;
  localparam logic [1:0] PAT_UNUSED = 2'd3;

  localparam logic CFG_TEMPO   = 1'b0;
  localparam logic CFG_PATTERN = 1'b1;

  typedef enum logic [2:0] {
    COND_TRUE,
    COND_PLAYING,
    COND_TOTAL_ZERO,
    COND_PAT_BLOCK,
    COND_PAT_DOWN,
    COND_IDX_LAST,
    COND_ACC_LT_STEP,
    COND_FULL
  } cond_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_IDX_CLR,
    DP_IDX_INC,
    DP_STOP_CLR,
    DP_APPEND,
    DP_START,
    DP_POS_LAST,
    DP_ACC_ADD,
    DP_ACC_SUB,
    DP_POS_ADV
  } dp_t;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_IDX,
    LAST_ACC
  } last_t;

  typedef struct packed {
    logic  emit;
    logic  on;
    last_t last_sel;
    logic  addr_pos;
    dp_t   dp;
    cond_t cond;
    logic  inv;
    logic  done;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_DONE       = 5'd0;
  localparam pc_t PC_LOAD       = 5'd1;
  localparam pc_t PC_LOAD_CLR   = 5'd2;
  localparam pc_t PC_LOAD_OFF   = 5'd3;
  localparam pc_t PC_LOAD_RST   = 5'd4;
  localparam pc_t PC_LOAD_CHK   = 5'd5;
  localparam pc_t PC_LOAD_APP   = 5'd6;
  localparam pc_t PC_STOP       = 5'd7;
  localparam pc_t PC_STOP_CLR   = 5'd8;
  localparam pc_t PC_STOP_OFF   = 5'd9;
  localparam pc_t PC_STOP_RST   = 5'd10;
  localparam pc_t PC_START      = 5'd11;
  localparam pc_t PC_START_CHK  = 5'd12;
  localparam pc_t PC_START_INIT = 5'd13;
  localparam pc_t PC_START_DIR  = 5'd14;
  localparam pc_t PC_START_LAST = 5'd15;
  localparam pc_t PC_START_ONE  = 5'd16;
  localparam pc_t PC_START_BLK  = 5'd17;
  localparam pc_t PC_TICK       = 5'd18;
  localparam pc_t PC_TICK_PAT   = 5'd19;
  localparam pc_t PC_TICK_ADD   = 5'd20;
  localparam pc_t PC_TICK_LOOP  = 5'd21;
  localparam pc_t PC_TICK_OFF   = 5'd22;
  localparam pc_t PC_TICK_ADV   = 5'd23;
  localparam pc_t PC_TICK_ON    = 5'd24;

  function automatic uword_t uw(input logic emit, input logic on, input last_t last_sel,
                                input logic addr_pos, input dp_t dp, input cond_t cond,
                                input logic inv, input logic done, input pc_t target);
    uword_t w;
    w.emit     = emit;
    w.on       = on;
    w.last_sel = last_sel;
    w.addr_pos = addr_pos;
    w.dp       = dp;
    w.cond     = cond;
    w.inv      = inv;
    w.done     = done;
    w.target   = target;
    return w;
  endfunction

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      PC_DONE:       w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_TRUE,        1'b1,
                            1'b1, PC_DONE);
      PC_LOAD:       w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_PLAYING,     1'b1,
                            1'b0, PC_LOAD_CHK);
      PC_LOAD_CLR:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_IDX_CLR,  COND_TRUE,        1'b1,
                            1'b0, PC_DONE);
      PC_LOAD_OFF:   w = uw(1'b1, 1'b0, LAST_IDX, 1'b0, DP_IDX_INC,  COND_IDX_LAST,    1'b1,
                            1'b0, PC_LOAD_OFF);
      PC_LOAD_RST:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_STOP_CLR, COND_TRUE,        1'b1,
                            1'b0, PC_DONE);
      PC_LOAD_CHK:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_FULL,        1'b0,
                            1'b0, PC_DONE);
      PC_LOAD_APP:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_APPEND,   COND_TRUE,        1'b1,
                            1'b1, PC_DONE);
      PC_STOP:       w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_PLAYING,     1'b1,
                            1'b0, PC_DONE);
      PC_STOP_CLR:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_IDX_CLR,  COND_TRUE,        1'b1,
                            1'b0, PC_DONE);
      PC_STOP_OFF:   w = uw(1'b1, 1'b0, LAST_IDX, 1'b0, DP_IDX_INC,  COND_IDX_LAST,    1'b1,
                            1'b0, PC_STOP_OFF);
      PC_STOP_RST:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_STOP_CLR, COND_TRUE,        1'b1,
                            1'b1, PC_DONE);
      PC_START:      w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_PLAYING,     1'b0,
                            1'b0, PC_DONE);
      PC_START_CHK:  w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_TOTAL_ZERO,  1'b0,
                            1'b0, PC_DONE);
      PC_START_INIT: w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_START,    COND_PAT_BLOCK,   1'b0,
                            1'b0, PC_START_BLK);
      PC_START_DIR:  w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_PAT_DOWN,    1'b1,
                            1'b0, PC_START_ONE);
      PC_START_LAST: w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_POS_LAST, COND_TRUE,        1'b1,
                            1'b0, PC_DONE);
      PC_START_ONE:  w = uw(1'b1, 1'b1, LAST_YES, 1'b1, DP_NONE,     COND_TRUE,        1'b1,
                            1'b1, PC_DONE);
      PC_START_BLK:  w = uw(1'b1, 1'b1, LAST_IDX, 1'b0, DP_IDX_INC,  COND_IDX_LAST,    1'b1,
                            1'b1, PC_START_BLK);
      PC_TICK:       w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_PLAYING,     1'b1,
                            1'b0, PC_DONE);
      PC_TICK_PAT:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_PAT_BLOCK,   1'b0,
                            1'b0, PC_DONE);
      PC_TICK_ADD:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_ACC_ADD,  COND_TRUE,        1'b1,
                            1'b0, PC_DONE);
      PC_TICK_LOOP:  w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_ACC_LT_STEP, 1'b0,
                            1'b0, PC_DONE);
      PC_TICK_OFF:   w = uw(1'b1, 1'b0, LAST_NO,  1'b1, DP_ACC_SUB,  COND_TRUE,        1'b1,
                            1'b0, PC_DONE);
      PC_TICK_ADV:   w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_POS_ADV,  COND_TRUE,        1'b1,
                            1'b0, PC_DONE);
      PC_TICK_ON:    w = uw(1'b1, 1'b1, LAST_ACC, 1'b1, DP_NONE,     COND_TRUE,        1'b0,
                            1'b0, PC_TICK_LOOP);
      default:       w = uw(1'b0, 1'b0, LAST_NO,  1'b0, DP_NONE,     COND_TRUE,        1'b1,
                            1'b1, PC_DONE);
    endcase
    return w;
  endfunction

  function automatic pc_t entry_pc(input logic [1:0] op);
    pc_t pc;
    unique case (op)
      OP_LOAD:  pc = PC_LOAD;
      OP_START: pc = PC_START;
      OP_TICK:  pc = PC_TICK;
      OP_STOP:  pc = PC_STOP;
      default:  pc = PC_DONE;
    endcase
    return pc;
  endfunction

endpackage

### hw/rtl/tempo_arpeggiator.sv
`timescale 1ns / 1ps

// Chord arpeggiator driven by a microcoded sequencer that executes one control word per
// cycle unless an event waits on a stalled output, and sends at most one note event per
// cycle through a single output register. After a request is accepted the sequencer
// runs a routine of its own, and the request channel stays stalled until it ends. A load
// first silences a playing chord, one note-off per sounding note, and then appends the
// note unless the chord is full. A stop silences a playing chord the same way and does
// nothing while idle. A start is ignored while playing or with an empty chord; otherwise
// it sends one note-on per note in block mode, or a single note-on in arpeggio mode (up
// from the first note, down from the last). A tick does nothing while idle or in block
// mode, and in arpeggio mode it advances one step per elapsed step length. Writing the
// tempo starts a divider that derives the step length in milliseconds; while it runs
// neither the request channel nor the configuration port accepts anything.
module tempo_arpeggiator #(
  parameter int MAX_NOTES = tarp_pkg::MaxNotesDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [tarp_pkg::NoteW-1:0] in_note_in,
  input  logic [tarp_pkg::MsW-1:0]   in_elapsed_ms,
  input  logic [tarp_pkg::VelW-1:0]  in_velocity_in,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tarp_pkg::NoteW-1:0] out_note_out,
  output logic                       out_note_on,
  output logic [tarp_pkg::VelW-1:0]  out_velocity_out,
  output logic                       out_last_event,

  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [tarp_pkg::BpmW-1:0]  cfg_data
);

  localparam int Cap  = (MAX_NOTES < tarp_pkg::CapLimit) ? MAX_NOTES : tarp_pkg::CapLimit;
  localparam int TotW = $clog2(Cap + 1);
  localparam int PosW = (Cap > 1) ? $clog2(Cap) : 1;

  localparam int NoteW = tarp_pkg::NoteW;
  localparam int VelW  = tarp_pkg::VelW;
  localparam int AccW  = tarp_pkg::AccW;
  localparam int BpmW  = tarp_pkg::BpmW;
  localparam int DivW  = tarp_pkg::DivW;
  localparam int DcW   = tarp_pkg::DivCntW;

  logic [NoteW-1:0]     notes_r [Cap];
  logic [TotW-1:0]      total_r, total_nxt;
  logic [PosW-1:0]      pos_r, pos_nxt;
  logic [PosW-1:0]      idx_r, idx_nxt;
  logic [AccW-1:0]      acc_r, acc_nxt;
  logic                 playing_r, playing_nxt;
  logic [VelW-1:0]      vel_r, vel_nxt;
  logic [1:0]           pat_r;
  logic [AccW-1:0]      step_r;

  logic                 busy_r, busy_nxt;
  tarp_pkg::pc_t        pc_r, pc_nxt;
  logic [NoteW-1:0]     note_in_r;
  logic [tarp_pkg::MsW-1:0] elapsed_r;
  logic [VelW-1:0]      vel_in_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [NoteW-1:0]     out_note_r, out_note_nxt;
  logic                 out_on_r, out_on_nxt;
  logic [VelW-1:0]      out_vel_r, out_vel_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [BpmW-1:0]      den_r;
  logic [BpmW-1:0]      rem_r;
  logic [DivW-1:0]      quo_r;
  logic [DcW-1:0]       div_cnt_r;
  logic                 div_busy;
  logic [BpmW:0]        trial;
  logic                 trial_ge;
  logic [DivW-1:0]      quo_new;
  logic [BpmW-1:0]      bpm_sat;

  tarp_pkg::uword_t     uw;
  logic                 cond_hit;
  logic                 take;
  logic                 hold;
  logic                 step_go;
  logic                 in_acc;
  logic                 pat_block;
  logic                 idx_last;
  logic [PosW-1:0]      pos_last;
  logic [PosW-1:0]      rd_addr;
  logic [NoteW-1:0]     rd_note;
  logic                 last_bit;

  assign div_busy  = (div_cnt_r != '0);
  assign cfg_ready = !div_busy;
  assign in_stall  = busy_r || div_busy;
  assign in_acc    = in_valid && !in_stall;

  assign out_valid        = out_valid_r;
  assign out_note_out     = out_note_r;
  assign out_note_on      = out_on_r;
  assign out_velocity_out = out_vel_r;
  assign out_last_event   = out_last_r;

  assign pat_block = (pat_r == tarp_pkg::PAT_BLOCK) || (pat_r == tarp_pkg::PAT_UNUSED);
  assign idx_last  = ((TotW'(idx_r) + TotW'(1)) == total_r);
  assign pos_last  = PosW'(total_r - TotW'(1));
  assign rd_addr   = uw.addr_pos ? pos_r : idx_r;
  assign rd_note   = notes_r[rd_addr];

  always_comb begin
    if (cfg_data < BpmW'(tarp_pkg::BpmMin)) begin
      bpm_sat = BpmW'(tarp_pkg::BpmMin);
    end else if (cfg_data > BpmW'(tarp_pkg::BpmMax)) begin
      bpm_sat = BpmW'(tarp_pkg::BpmMax);
    end else begin
      bpm_sat = cfg_data;
    end
    trial    = {rem_r, quo_r[DivW-1]};
    trial_ge = (trial >= {1'b0, den_r});
    quo_new  = {quo_r[DivW-2:0], trial_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
      pat_r     <= tarp_pkg::PAT_BLOCK;
      step_r    <= AccW'(tarp_pkg::StepReset);
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tarp_pkg::CFG_PATTERN) begin
          pat_r <= cfg_data[1:0];
        end else begin
          div_cnt_r <= DcW'(DivW);
        end
      end else if (div_busy) begin
        div_cnt_r <= div_cnt_r - DcW'(1);
        if (div_cnt_r == DcW'(1)) begin
          step_r <= AccW'(quo_new >> $clog2(tarp_pkg::StepsPerBeat));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_valid && cfg_ready && (cfg_index == tarp_pkg::CFG_TEMPO)) begin
      den_r <= bpm_sat;
      rem_r <= '0;
      quo_r <= DivW'(tarp_pkg::MsPerMinute);
    end else if (div_busy) begin
      rem_r <= trial_ge ? BpmW'(trial - {1'b0, den_r}) : BpmW'(trial);
      quo_r <= quo_new;
    end
  end

  always_comb begin
    uw = tarp_pkg::ucode_rom(pc_r);

    unique case (uw.cond)
      tarp_pkg::COND_TRUE:        cond_hit = 1'b1;
      tarp_pkg::COND_PLAYING:     cond_hit = playing_r;
      tarp_pkg::COND_TOTAL_ZERO:  cond_hit = (total_r == '0);
      tarp_pkg::COND_PAT_BLOCK:   cond_hit = pat_block;
      tarp_pkg::COND_PAT_DOWN:    cond_hit = (pat_r == tarp_pkg::PAT_DOWN);
      tarp_pkg::COND_IDX_LAST:    cond_hit = idx_last;
      tarp_pkg::COND_ACC_LT_STEP: cond_hit = (acc_r < step_r);
      tarp_pkg::COND_FULL:        cond_hit = (total_r == TotW'(Cap));
      default:                    cond_hit = 1'b0;
    endcase
    take = cond_hit ^ uw.inv;

    unique case (uw.last_sel)
      tarp_pkg::LAST_NO:  last_bit = 1'b0;
      tarp_pkg::LAST_YES: last_bit = 1'b1;
      tarp_pkg::LAST_IDX: last_bit = idx_last;
      tarp_pkg::LAST_ACC: last_bit = (acc_r < step_r);
      default:            last_bit = 1'b0;
    endcase

    hold    = uw.emit && out_valid_r && out_stall;
    step_go = busy_r && !hold;

    busy_nxt    = busy_r;
    pc_nxt      = pc_r;
    total_nxt   = total_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    playing_nxt = playing_r;
    vel_nxt     = vel_r;

    if (in_acc) begin
      busy_nxt = 1'b1;
      pc_nxt   = tarp_pkg::entry_pc(in_op);
    end else if (step_go) begin
      if (take) begin
        pc_nxt = uw.target;
      end else if (uw.done) begin
        busy_nxt = 1'b0;
        pc_nxt   = tarp_pkg::PC_DONE;
      end else begin
        pc_nxt = pc_r + tarp_pkg::pc_t'(1);
      end

      unique case (uw.dp)
        tarp_pkg::DP_NONE: begin
        end
        tarp_pkg::DP_IDX_CLR: begin
          idx_nxt = '0;
        end
        tarp_pkg::DP_IDX_INC: begin
          idx_nxt = idx_r + PosW'(1);
        end
        tarp_pkg::DP_STOP_CLR: begin
          playing_nxt = 1'b0;
          total_nxt   = '0;
          pos_nxt     = '0;
          acc_nxt     = '0;
        end
        tarp_pkg::DP_APPEND: begin
          total_nxt = total_r + TotW'(1);
        end
        tarp_pkg::DP_START: begin
          vel_nxt     = vel_in_r;
          playing_nxt = 1'b1;
          pos_nxt     = '0;
          idx_nxt     = '0;
          acc_nxt     = '0;
        end
        tarp_pkg::DP_POS_LAST: begin
          pos_nxt = pos_last;
        end
        tarp_pkg::DP_ACC_ADD: begin
          acc_nxt = acc_r + AccW'(elapsed_r);
        end
        tarp_pkg::DP_ACC_SUB: begin
          acc_nxt = acc_r - step_r;
        end
        tarp_pkg::DP_POS_ADV: begin
          if (pat_r == tarp_pkg::PAT_UP) begin
            pos_nxt = (pos_r == pos_last) ? '0 : pos_r + PosW'(1);
          end else begin
            pos_nxt = (pos_r == '0) ? pos_last : pos_r - PosW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    out_valid_nxt = out_valid_r;
    out_note_nxt  = out_note_r;
    out_on_nxt    = out_on_r;
    out_vel_nxt   = out_vel_r;
    out_last_nxt  = out_last_r;
    if (step_go && uw.emit) begin
      out_valid_nxt = 1'b1;
      out_note_nxt  = rd_note;
      out_on_nxt    = uw.on;
      out_vel_nxt   = uw.on ? vel_r : '0;
      out_last_nxt  = last_bit;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= tarp_pkg::PC_DONE;
      total_r     <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      acc_r       <= '0;
      playing_r   <= 1'b0;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      playing_r   <= playing_nxt;
      vel_r       <= vel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_note_r <= out_note_nxt;
    out_on_r   <= out_on_nxt;
    out_vel_r  <= out_vel_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      note_in_r <= in_note_in;
      elapsed_r <= in_elapsed_ms;
      vel_in_r  <= in_velocity_in;
    end
    if (step_go && (uw.dp == tarp_pkg::DP_APPEND)) begin
      notes_r[total_r[PosW-1:0]] <= note_in_r;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy |-> (step_r >= AccW'(50)) && (step_r <= AccW'(750)))
    else $error("step length out of range");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TotW'(Cap))
    else $error("chord holds more notes than its capacity");

  a_playing_notes: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (total_r != '0) && (TotW'(pos_r) < total_r))
    else $error("playing with an empty chord or a bad position");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r && (pc_r != tarp_pkg::PC_DONE))
    else $error("accepted request did not start a routine");

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(busy_r))
    else $error("event produced while the sequencer was idle");

endmodule
